@@ rtl/ole_pkg.sv @@
// Shared request, status and field-width constants for the ordered list engine.
package ole_pkg;

    localparam int REQ_W    = 3;
    localparam int IN_VAL_W = 32;
    localparam int IDX_W    = 5;
    localparam int STAT_W   = 3;
    localparam int MIDX_W   = 4;
    localparam int CNT_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam int MAX_RESULTS = 16;
    localparam int NM_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_VAL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_IDX = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_FST = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

endpackage

@@ rtl/ole_store.sv @@
// Element store: one write port, one registered read port.
module ole_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ordered_list_engine.sv @@
// Ordered list engine top level: request sequencer, walk pipeline and result register.
//
//  channel | direction | tdata (low bit up)                          | side band
//  s_      | in        | item_value[31:0], elem_index[36:32], pad    | tuser = req_type
//  m_      | out       | status[2:0], match_index[6:3],              | tlast = last_of_run
//          |           | entry_count[11:7], pad                      |
//
// One request at a time; the store walk moves one entry per cycle through the read port,
// but a search pauses while a further match waits for a free output register. A delete
// by value scans, then shifts the later entries down; an insert shifts entries up from
// the tail before it writes. A result that waits on m_tready delays the next accept.
// Reset clears the length and the control state only; the store needs no clearing pass.
// A new request is taken while the last result still waits in the output register.
module ordered_list_engine #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ole_pkg::S_TDATA_W-1:0]  s_tdata,  // item_value, elem_index
    input  logic [ole_pkg::REQ_W-1:0]      s_tuser,  // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ole_pkg::M_TDATA_W-1:0]  m_tdata,  // status, match_index, entry_count
    output logic                           m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > ole_pkg::IDX_W) ? LW : ole_pkg::IDX_W;
    localparam int MW = (AW > ole_pkg::MIDX_W) ? AW : ole_pkg::MIDX_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SHL  = 6'b000100,
        S_SHR  = 6'b001000,
        S_PUT  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LW-1:0]                 len_reg, len_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [LW-1:0]                 cnt_reg, cnt_next;
    logic                          pv_reg, pv_next;
    logic [AW-1:0]                 pidx_reg, pidx_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [ole_pkg::REQ_W-1:0]     kind_reg, kind_next;
    logic [VALUE_WIDTH-1:0]        val_reg, val_next;
    logic [ole_pkg::STAT_W-1:0]    stat_reg, stat_next;
    logic [AW-1:0]                 midx_reg, midx_next;
    logic                          hold_reg, hold_next;
    logic [ole_pkg::NM_W-1:0]      nm_reg, nm_next;

    logic                          out_vld_reg, out_vld_next;
    logic [ole_pkg::STAT_W-1:0]    ostat_reg, ostat_next;
    logic [ole_pkg::MIDX_W-1:0]    omidx_reg, omidx_next;
    logic [ole_pkg::CNT_W-1:0]     olen_reg, olen_next;
    logic                          olast_reg, olast_next;

    logic                          rd_en;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [VALUE_WIDTH-1:0]        wr_data;
    logic [VALUE_WIDTH-1:0]        rd_data;

    logic [CW-1:0]                 len_ext;
    logic [CW-1:0]                 idx_ext;
    logic [MW-1:0]                 midx_ext;
    logic [ole_pkg::CNT_W-1:0]     len_out;
    logic [ole_pkg::MIDX_W-1:0]    midx_out;
    logic                          slot_free;

    assign len_ext   = CW'(len_reg);
    assign idx_ext   = CW'(s_tdata[36:32]);
    assign midx_ext  = MW'(midx_reg);
    assign len_out   = len_ext[ole_pkg::CNT_W-1:0];
    assign midx_out  = midx_ext[ole_pkg::MIDX_W-1:0];
    assign slot_free = !out_vld_reg || m_tready;

    ole_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        logic hit;
        logic stall;
        logic walk;

        state_next   = state_reg;
        len_next     = len_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        pv_next      = pv_reg;
        pidx_next    = pidx_reg;
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        stat_next    = stat_reg;
        midx_next    = midx_reg;
        hold_next    = hold_reg;
        nm_next      = nm_reg;
        out_vld_next = out_vld_reg && !m_tready;
        ostat_next   = ostat_reg;
        omidx_next   = omidx_reg;
        olen_next    = olen_reg;
        olast_next   = olast_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = val_reg;
        hit          = pv_reg && (rd_data == val_reg);
        stall        = 1'b0;
        walk         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser;
                    val_next  = VALUE_WIDTH'($signed(s_tdata[31:0]));
                    stat_next = ole_pkg::STAT_OK;
                    midx_next = '0;
                    hold_next = 1'b0;
                    nm_next   = '0;
                    pv_next   = 1'b0;
                    ptr_next  = '0;
                    cnt_next  = '0;
                    unique case (s_tuser) inside
                        ole_pkg::REQ_APPEND: begin
                            if (len_reg == LW'(CAPACITY)) begin
                                stat_next  = ole_pkg::STAT_FULL;
                                state_next = S_DONE;
                            end else begin
                                pos_next   = AW'(len_reg);
                                state_next = S_PUT;
                            end
                        end
                        ole_pkg::REQ_INSERT: begin
                            if (idx_ext > len_ext) begin
                                stat_next  = ole_pkg::STAT_BAD_INDEX;
                                state_next = S_DONE;
                            end else if (len_reg == LW'(CAPACITY)) begin
                                stat_next  = ole_pkg::STAT_FULL;
                                state_next = S_DONE;
                            end else begin
                                pos_next   = AW'(idx_ext);
                                ptr_next   = AW'(len_reg - LW'(1));
                                cnt_next   = LW'(len_ext - idx_ext);
                                state_next = S_SHR;
                            end
                        end
                        ole_pkg::REQ_DEL_VAL,
                        ole_pkg::REQ_SEARCH: begin
                            if (len_reg == '0) begin
                                stat_next  = ole_pkg::STAT_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                cnt_next   = len_reg;
                                state_next = S_SCAN;
                            end
                        end
                        ole_pkg::REQ_DEL_IDX: begin
                            if (idx_ext == '0 && len_reg == '0) begin
                                stat_next  = ole_pkg::STAT_EMPTY;
                                state_next = S_DONE;
                            end else if (idx_ext >= len_ext) begin
                                stat_next  = ole_pkg::STAT_BAD_INDEX;
                                state_next = S_DONE;
                            end else begin
                                ptr_next   = AW'(idx_ext + CW'(1));
                                cnt_next   = LW'(len_ext - idx_ext - CW'(1));
                                state_next = S_SHL;
                            end
                        end
                        ole_pkg::REQ_DEL_FST: begin
                            if (len_reg == '0) begin
                                stat_next  = ole_pkg::STAT_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                ptr_next   = AW'(1);
                                cnt_next   = len_reg - LW'(1);
                                state_next = S_SHL;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (cnt_reg == '0 && !pv_reg) begin
                    if (kind_reg == ole_pkg::REQ_SEARCH && hold_reg) begin
                        stat_next = ole_pkg::STAT_OK;
                        hold_next = 1'b0;
                    end else begin
                        stat_next = ole_pkg::STAT_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end else begin
                    stall = hit && (kind_reg == ole_pkg::REQ_SEARCH) && hold_reg && !slot_free;
                    walk  = !stall;
                end
            end

            S_SHL: begin
                if (cnt_reg == '0 && !pv_reg) begin
                    len_next   = len_reg - LW'(1);
                    stat_next  = ole_pkg::STAT_OK;
                    state_next = S_DONE;
                end else begin
                    wr_en   = pv_reg;
                    wr_addr = pidx_reg - AW'(1);
                    wr_data = rd_data;
                    walk    = 1'b1;
                end
            end

            S_SHR: begin
                if (cnt_reg == '0 && !pv_reg) begin
                    state_next = S_PUT;
                end else begin
                    wr_en   = pv_reg;
                    wr_addr = pidx_reg + AW'(1);
                    wr_data = rd_data;
                    walk    = 1'b1;
                end
            end

            S_PUT: begin
                wr_en      = 1'b1;
                len_next   = len_reg + LW'(1);
                stat_next  = ole_pkg::STAT_OK;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (slot_free) begin
                    out_vld_next = 1'b1;
                    ostat_next   = stat_reg;
                    omidx_next   = midx_out;
                    olen_next    = len_out;
                    olast_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (walk) begin
            rd_en     = (cnt_reg != '0);
            pv_next   = rd_en;
            pidx_next = ptr_reg;
            if (rd_en) begin
                cnt_next = cnt_reg - LW'(1);
                ptr_next = (state_reg == S_SHR) ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
            end
        end

        // match handling overrides the walk
        if (state_reg == S_SCAN && hit && !stall) begin
            if (kind_reg == ole_pkg::REQ_DEL_VAL) begin
                ptr_next   = pidx_reg + AW'(1);
                cnt_next   = len_reg - LW'(pidx_reg) - LW'(1);
                pv_next    = 1'b0;
                state_next = S_SHL;
            end else begin
                if (hold_reg) begin
                    out_vld_next = 1'b1;
                    ostat_next   = ole_pkg::STAT_OK;
                    omidx_next   = midx_out;
                    olen_next    = len_out;
                    olast_next   = 1'b0;
                end
                hold_next = 1'b1;
                midx_next = pidx_reg;
                nm_next   = nm_reg + ole_pkg::NM_W'(1);
                if (nm_reg == ole_pkg::NM_W'(ole_pkg::MAX_RESULTS - 1)) begin
                    cnt_next = '0;
                    pv_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            pv_reg      <= 1'b0;
            hold_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            nm_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            pv_reg      <= pv_next;
            hold_reg    <= hold_next;
            out_vld_reg <= out_vld_next;
            cnt_reg     <= cnt_next;
            nm_reg      <= nm_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        pidx_reg  <= pidx_next;
        pos_reg   <= pos_next;
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        midx_reg  <= midx_next;
        ostat_reg <= ostat_next;
        omidx_reg <= omidx_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {4'b0000, olen_reg, omidx_reg, ostat_reg};

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(CAPACITY))
        else $error("list length beyond capacity");

    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUT) |=> (len_reg == $past(len_reg) + LW'(1)))
        else $error("insert did not grow the list by one");

    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[2:0] == ole_pkg::STAT_OK))
        else $error("non-final result without ok status");

    a_nm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nm_reg <= ole_pkg::NM_W'(ole_pkg::MAX_RESULTS))
        else $error("match count beyond result limit");
`endif

endmodule
